// ===== hdl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the start/stop byte packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Packet geometry
  localparam int CHANNELS     = 8;
  localparam int PACKET_BYTES = 33;

  // Derived widths and limits
  localparam int POS_W        = 6;
  localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_END   = 2 + 3 * CHANNELS;
  // highest channel whose three bytes all lie inside the packet
  localparam int MAX_WHOLE_CH = (PACKET_BYTES - 5) / 3;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int SAMP_W   = 24;
  localparam int SCALE_W  = 24;
  localparam int IDX_W    = 4;
  localparam int RESULT_W = 48;

  // Framing bytes
  localparam logic [BYTE_W-1:0] START_BYTE  = 8'hA0;
  localparam logic [BYTE_W-1:0] STOP_BYTE_A = 8'hC0;
  localparam logic [BYTE_W-1:0] STOP_BYTE_B = 8'hC1;

  // Configuration register map
  localparam int                 CFG_AW      = 3;
  localparam int                 CFG_DW      = 32;
  localparam logic               REG_SCALE   = 1'b0;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd95990;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_END = 1'b1;

  typedef logic [CHANNELS-1:0][SAMP_W-1:0] sample_vec_t;

  // Packet-end handoff from deframer to emitter
  typedef struct packed {
    logic done;
    logic bad;
  } pkt_end_t;

endpackage

// ===== hdl/spd_byte_if.sv =====
// ----------------------------------------------------------------------------
// spd_byte_if
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface spd_byte_if;
  import spd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/spd_result_if.sv =====
// ----------------------------------------------------------------------------
// spd_result_if
// Valid/ready channel carrying one scaled channel sample per beat.
// ----------------------------------------------------------------------------
interface spd_result_if;
  import spd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [IDX_W-1:0]           channel_index;
  logic signed [RESULT_W-1:0] scaled_sample;
  logic                       status;
  logic                       last;

  modport source (output valid, output channel_index, output scaled_sample,
                  output status, output last, input ready);
  modport sink   (input valid, input channel_index, input scaled_sample,
                  input status, input last, output ready);
endinterface

// ===== hdl/spd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// spd_cfg_regs
// APB-style register port holding the sample scale factor.
// ----------------------------------------------------------------------------
module spd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [spd_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [spd_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [spd_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  output logic [spd_pkg::SCALE_W-1:0]   scale
);
  import spd_pkg::*;

  logic [SCALE_W-1:0] scale_r;
  logic [SCALE_W-1:0] scale_nxt;
  logic               wr_hit;

  // Write decode: register index is the word address
  assign wr_hit = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[CFG_AW-1:2] == {(CFG_AW-2){REG_SCALE}});

  always_comb begin
    scale_nxt = scale_r;
    if (wr_hit) begin
      scale_nxt = cfg_pwdata[SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  // Read mux
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_AW-1:2] == {(CFG_AW-2){REG_SCALE}}) begin
      cfg_prdata = {{(CFG_DW-SCALE_W){1'b0}}, scale_r};
    end
  end

  assign cfg_pready = 1'b1;
  assign scale      = scale_r;

endmodule

// ===== hdl/spd_deframer.sv =====
// ----------------------------------------------------------------------------
// spd_deframer
// Hunts for the start byte, assembles 24-bit samples and checks the stop byte.
// ----------------------------------------------------------------------------
module spd_deframer (
  input  logic                  clk,
  input  logic                  rst_n,
  spd_byte_if.sink              in_ch,
  input  logic                  emit_busy,
  output spd_pkg::pkt_end_t     pkt_end,
  output spd_pkg::sample_vec_t  samples
);
  import spd_pkg::*;

  logic [POS_W-1:0]  pos_r,  pos_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [CH_W-1:0]   chan_r, chan_nxt;
  logic [15:0]       asm_r,  asm_nxt;
  logic [SAMP_W-1:0] store_r [CHANNELS];

  logic              accept;
  logic              in_samples;
  logic              wr_en;
  logic [SAMP_W-1:0] wr_data;
  logic [BYTE_W-1:0] b;

  // Hold off the final byte while the previous packet is still draining
  assign in_ch.ready = !(emit_busy && (pos_r == LAST_POS));
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign in_samples  = (int'(pos_r) >= 2) && (int'(pos_r) < SAMPLE_END);

  // Framing and sample assembly
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    chan_nxt  = chan_r;
    asm_nxt   = asm_r;
    wr_en     = 1'b0;
    wr_data   = {asm_r, b};
    pkt_end   = '0;
    if (accept) begin
      if (pos_r == '0) begin
        if (b == START_BYTE) begin
          pos_nxt   = POS_W'(1);
          phase_nxt = 2'd0;
          chan_nxt  = '0;
        end
      end else begin
        if (in_samples) begin
          case (phase_r)
            2'd0: begin
              asm_nxt   = {8'h00, b};
              phase_nxt = 2'd1;
            end
            2'd1: begin
              asm_nxt   = {asm_r[7:0], b};
              phase_nxt = 2'd2;
            end
            default: begin
              wr_en     = 1'b1;
              phase_nxt = 2'd0;
              chan_nxt  = chan_r + CH_W'(1);
            end
          endcase
        end
        if (pos_r < LAST_POS) begin
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          pos_nxt      = '0;
          pkt_end.done = 1'b1;
          pkt_end.bad  = (b != STOP_BYTE_A) && (b != STOP_BYTE_B);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= 2'd0;
      chan_r  <= '0;
      asm_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      chan_r  <= chan_nxt;
      asm_r   <= asm_nxt;
    end
  end

  // Sample store, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[chan_r] <= wr_data;
    end
  end

  // Store view including this beat's write, for the end-of-packet snapshot
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      samples[i] = (wr_en && (int'(chan_r) == i)) ? wr_data : store_r[i];
    end
  end

  // Assertions
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("byte position past packet end");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (emit_busy && pos_r == LAST_POS))
    else $error("input stalled without a pending packet end");

  a_hunt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_end.done |=> pos_r == '0)
    else $error("deframer did not return to hunting");

endmodule

// ===== hdl/spd_emitter.sv =====
// ----------------------------------------------------------------------------
// spd_emitter
// Snapshots a finished packet and sends one scaled sample per beat.
// ----------------------------------------------------------------------------
module spd_emitter (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spd_pkg::pkt_end_t      pkt_end,
  input  spd_pkg::sample_vec_t   samples,
  input  logic [spd_pkg::SCALE_W-1:0] scale,
  output logic                   emit_busy,
  spd_result_if.source           out_ch
);
  import spd_pkg::*;

  logic              busy_r,  busy_nxt;
  logic              err_r,   err_nxt;
  logic [CH_W-1:0]   ch_r,    ch_nxt;
  logic [SAMP_W-1:0] shadow_r [CHANNELS];

  logic                       oval_r,  oval_nxt;
  logic [IDX_W-1:0]           oidx_r;
  logic signed [RESULT_W-1:0] osamp_r;
  logic                       ostat_r;
  logic                       olast_r;

  logic                       load;
  logic                       beat_last;
  logic                       whole;
  logic [SAMP_W-1:0]          sel;
  logic signed [RESULT_W:0]   prod;

  assign load      = busy_r && (!oval_r || out_ch.ready);
  assign beat_last = err_r || (ch_r == CH_W'(CHANNELS - 1));
  assign whole     = int'(ch_r) <= MAX_WHOLE_CH;
  assign sel       = shadow_r[ch_r];
  assign prod      = $signed(sel) * $signed({1'b0, scale});

  // Channel sequencer
  always_comb begin
    busy_nxt = busy_r;
    err_nxt  = err_r;
    ch_nxt   = ch_r;
    if (pkt_end.done) begin
      busy_nxt = 1'b1;
      err_nxt  = pkt_end.bad;
      ch_nxt   = '0;
    end else if (load) begin
      ch_nxt = ch_r + CH_W'(1);
      if (beat_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      err_r  <= 1'b0;
      ch_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      err_r  <= err_nxt;
      ch_r   <= ch_nxt;
    end
  end

  // Packet snapshot
  always_ff @(posedge clk) begin
    if (pkt_end.done) begin
      for (int i = 0; i < CHANNELS; i++) begin
        shadow_r[i] <= samples[i];
      end
    end
  end

  // Output register
  always_comb begin
    oval_nxt = oval_r;
    if (load) begin
      oval_nxt = 1'b1;
    end else if (out_ch.ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oidx_r  <= err_r ? '0 : IDX_W'(ch_r);
      osamp_r <= (err_r || !whole) ? '0 : prod[RESULT_W-1:0];
      ostat_r <= err_r ? STATUS_BAD_END : STATUS_OK;
      olast_r <= beat_last;
    end
  end

  assign emit_busy            = busy_r;
  assign out_ch.valid         = oval_r;
  assign out_ch.channel_index = oidx_r;
  assign out_ch.scaled_sample = osamp_r;
  assign out_ch.status        = ostat_r;
  assign out_ch.last          = olast_r;

  // Assertions
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(pkt_end.done && busy_r))
    else $error("packet ended while previous one still draining");

  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(pkt_end.done))
    else $error("emitter started without a packet end");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && ostat_r) |-> (olast_r && osamp_r == '0 && oidx_r == '0))
    else $error("malformed error beat");

endmodule

// ===== hdl/sensor_packet_deframer_24bit_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_packet_deframer_24bit_unit
// Start/stop byte deframer producing scaled 24-bit channel samples.
//
//   Channel   Dir  Beat                         Handshake
//   in_ch     in   one received byte            valid/ready
//   out_ch    out  channel, sample, status      valid/ready
//   cfg_*     in   scale factor register        APB, pready tied high
//
// One byte is accepted per cycle; the final byte sets busy, then results stream
// from the output register one per cycle (CHANNELS beats, or one error beat).
// The per-beat path is one 24x25 multiply between the snapshot and output regs.
// Input stalls only on a packet's final byte while the previous packet drains.
// Output backpressure holds the output register; input keeps flowing otherwise.
// Synchronous active-low reset returns to hunting with the default scale.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_24bit_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  spd_byte_if.sink                    in_ch,
  spd_result_if.source                out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [spd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [spd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [spd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import spd_pkg::*;

  logic [SCALE_W-1:0] scale;
  logic               emit_busy;
  pkt_end_t           pkt_end;
  sample_vec_t        samples;

  spd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .scale       (scale)
  );

  spd_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .emit_busy (emit_busy),
    .pkt_end   (pkt_end),
    .samples   (samples)
  );

  spd_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_end   (pkt_end),
    .samples   (samples),
    .scale     (scale),
    .emit_busy (emit_busy),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/sv/deframer_checker.sv =====
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte, result and register ports of the packet deframer. It keeps
// its own copy of the framing state and scale factor, and works out the sample
// beats each accepted byte produces. It compares every result beat field by
// field with the oldest expected beat. It also checks register reads. It hands
// the error count and the number of beats still due to the testbench top.
// ----------------------------------------------------------------------------
module deframer_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  spd_byte_if                        in_mon,
  spd_result_if                      out_mon,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [spd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [spd_pkg::CFG_DW-1:0] cfg_pwdata,
  input  logic [spd_pkg::CFG_DW-1:0] cfg_prdata,
  input  logic                       cfg_pready,
  output int                         error_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spd_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]           channel_index;
    logic signed [RESULT_W-1:0] scaled_sample;
    logic                       status;
    logic                       last;
  } sample_beat_t;

  sample_beat_t       expected_beats[$];
  logic [SCALE_W-1:0] scale_q;
  logic [POS_W-1:0]   frame_pos;
  logic [15:0]        partial_sample;
  logic [SAMP_W-1:0]  channel_samples [CHANNELS];
  int                 errs;

  // exact signed product, truncated to the result width
  function automatic logic signed [RESULT_W-1:0] scaled(input logic [SAMP_W-1:0]  raw,
                                                        input logic [SCALE_W-1:0] k);
    logic signed [RESULT_W-1:0] s_ext;
    logic signed [RESULT_W-1:0] k_ext;
    s_ext = {{(RESULT_W-SAMP_W){raw[SAMP_W-1]}}, raw};
    k_ext = {{(RESULT_W-SCALE_W){1'b0}}, k};
    return s_ext * k_ext;
  endfunction

  // advance the framing state by one byte and queue any beats it releases
  function automatic void take_byte(input logic [BYTE_W-1:0] b);
    int           pos;
    int           off;
    sample_beat_t beat;
    pos = int'(frame_pos);

    // hunting: only the start byte opens a packet
    if (pos == 0) begin
      if (b == START_BYTE)
        frame_pos = POS_W'(1);
      return;
    end

    // sample area: three bytes per channel, big-endian
    if (pos >= 2 && pos < SAMPLE_END) begin
      off = pos - 2;
      case (off % 3)
        0: partial_sample = {8'h00, b};
        1: partial_sample = {partial_sample[7:0], b};
        default: begin
          if (off / 3 < CHANNELS)
            channel_samples[off / 3] = {partial_sample, b};
        end
      endcase
    end

    if (pos < PACKET_BYTES - 1) begin
      frame_pos = POS_W'(pos + 1);
      return;
    end

    // final byte: stop check, then back to hunting
    frame_pos = '0;
    if (b != STOP_BYTE_A && b != STOP_BYTE_B) begin
      beat.channel_index = '0;
      beat.scaled_sample = '0;
      beat.status        = STATUS_BAD_END;
      beat.last          = 1'b1;
      expected_beats.push_back(beat);
      return;
    end

    for (int ch = 0; ch < CHANNELS; ch++) begin
      beat.channel_index = IDX_W'(ch);
      // a channel cut off by the end of the packet reads as zero
      beat.scaled_sample = (2 + 3 * ch + 2 <= PACKET_BYTES - 1) ?
                           scaled(channel_samples[ch], scale_q) : '0;
      beat.status        = STATUS_OK;
      beat.last          = (ch == CHANNELS - 1);
      expected_beats.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    sample_beat_t beat;
    if (!rst_n) begin
      scale_q        = SCALE_RESET;
      frame_pos      = '0;
      partial_sample = '0;
      for (int i = 0; i < CHANNELS; i++)
        channel_samples[i] = '0;
      expected_beats.delete();
      errs = 0;
    end else begin
      // result beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no expected beat pending");
          errs++;
        end else begin
          beat = expected_beats.pop_front();
          if (out_mon.channel_index !== beat.channel_index) begin
            $error("channel_index: expected %0d, got %0d",
                   beat.channel_index, out_mon.channel_index);
            errs++;
          end
          if (out_mon.scaled_sample !== beat.scaled_sample) begin
            $error("scaled_sample: expected %0d, got %0d",
                   beat.scaled_sample, out_mon.scaled_sample);
            errs++;
          end
          if (out_mon.status !== beat.status) begin
            $error("status: expected %0d, got %0d", beat.status, out_mon.status);
            errs++;
          end
          if (out_mon.last !== beat.last) begin
            $error("last: expected %0d, got %0d", beat.last, out_mon.last);
            errs++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready)
        take_byte(in_mon.rx_byte);

      // register access phase; unmapped writes are dropped
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[1:0] == 2'b00 &&
          (cfg_paddr >> 2) == CFG_AW'(REG_SCALE)) begin
        if (cfg_pwrite) begin
          scale_q = cfg_pwdata[SCALE_W-1:0];
        end else if (cfg_prdata !== CFG_DW'(scale_q)) begin
          $error("scale_factor: expected %0d, got %0d", scale_q, cfg_prdata);
          errs++;
        end
      end
    end
    error_count <= errs;
    pending     <= expected_beats.size();
  end

endmodule

// ===== tb/sv/sensor_packet_deframer_24bit_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_packet_deframer_24bit_unit_tb
// Byte-stream stimulus for the packet deframer. A directed part covers the
// sample extremes, both stop bytes, bad stop bytes, start bytes inside a
// packet, noise while hunting and the scale register limits. A random part
// sends mostly well-formed packets with random content, plus noise and cut-off
// packets. Both sides idle in random bursts, and the result side holds off for
// a long stretch once. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_24bit_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spd_pkg::*;

  localparam int                LIMIT_CYCLES  = 200000;
  localparam int                HOLD_CYCLES   = 150;
  localparam int                RANDOM_BYTES  = 90;
  localparam logic [CFG_AW-1:0] SCALE_ADDR    = CFG_AW'(4 * int'(REG_SCALE));
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = CFG_AW'(4 * (int'(REG_SCALE) + 1));

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                error_count;
  int                pending;
  int                cycle_count = 0;
  int                packet_bytes_sent;
  bit                src_idle;
  bit                snk_idle;
  bit                hold_req;
  logic [BYTE_W-1:0] frame [PACKET_BYTES];

  spd_byte_if   in_ch ();
  spd_result_if out_ch ();

  sensor_packet_deframer_24bit_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  deframer_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .error_count (error_count),
    .pending     (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: ready with random stall bursts, one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (snk_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one byte beat; valid stays high on return so back-to-back beats need no toggle
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // first nbytes of the current frame
  task automatic send_frame(input int nbytes);
    for (int i = 0; i < nbytes; i++)
      send_byte(frame[i]);
    packet_bytes_sent += nbytes;
  endtask

  // start byte, random body, given stop byte
  function automatic void fill_frame(input logic [BYTE_W-1:0] stop_b);
    for (int i = 1; i < PACKET_BYTES - 1; i++)
      frame[i] = BYTE_W'($urandom());
    frame[0]                = START_BYTE;
    frame[PACKET_BYTES - 1] = stop_b;
  endfunction

  // big-endian sample bytes; the stop position is left alone
  function automatic void put_sample(input int ch, input logic [SAMP_W-1:0] v);
    int p;
    for (int j = 0; j < 3; j++) begin
      p = 2 + 3 * ch + j;
      if (p < PACKET_BYTES - 1)
        frame[p] = v[8 * (2 - j) +: 8];
    end
  endfunction

  function automatic logic [SAMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'hFFFFFF;
      3:       return 24'h000000;
      default: return SAMP_W'($urandom());
    endcase
  endfunction

  // APB setup + access, then idle with psel low so psel never toggles in a step
  task automatic apb_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait for every expected beat, plus a short tail
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // new scale between packets, sometimes with junk upper bits or a stray address
  task automatic rescale();
    logic [CFG_DW-1:0] v;
    drain();
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = CFG_DW'(24'hFFFFFF);
      2:       v = CFG_DW'(1);
      default: v = $urandom();
    endcase
    apb_access(1'b1, SCALE_ADDR, v);
    if ($urandom_range(0, 2) == 0)
      apb_access(1'b1, UNMAPPED_ADDR, $urandom());
    if ($urandom_range(0, 1) == 0)
      apb_access(1'b0, SCALE_ADDR, '0);
  endtask

  initial begin
    logic [BYTE_W-1:0] nb;
    logic [BYTE_W-1:0] stop_b;
    int                pkt;
    int                nbytes;

    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    rst_n         <= 1'b0;
    src_idle          = 1'b0;
    snk_idle          = 1'b0;
    hold_req          = 1'b0;
    packet_bytes_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // reset scale readback, then stop bytes and noise while hunting
    apb_access(1'b0, SCALE_ADDR, '0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(STOP_BYTE_A);
    send_byte(STOP_BYTE_B);

    // sample extremes at reset scale; start byte as data right after start
    fill_frame(STOP_BYTE_A);
    frame[1] = START_BYTE;
    put_sample(0, 24'h7FFFFF);
    put_sample(1, 24'h800000);
    put_sample(2, 24'hFFFFFF);
    put_sample(3, 24'h000000);
    put_sample(4, 24'h000001);
    put_sample(5, {3{START_BYTE}});
    put_sample(6, {3{STOP_BYTE_A}});
    put_sample(7, 24'h123456);
    send_frame(PACKET_BYTES);

    // largest scale, other stop byte
    drain();
    apb_access(1'b1, SCALE_ADDR, CFG_DW'(24'hFFFFFF));
    apb_access(1'b0, SCALE_ADDR, '0);
    frame[PACKET_BYTES - 1] = STOP_BYTE_B;
    send_frame(PACKET_BYTES);

    // upper bits dropped, unmapped write ignored
    drain();
    apb_access(1'b1, SCALE_ADDR, 32'hFF800001);
    apb_access(1'b1, UNMAPPED_ADDR, 32'hFFFFFFFF);
    apb_access(1'b0, SCALE_ADDR, '0);

    // bad stop bytes: plain, and a start byte in the stop slot (no resync)
    fill_frame(8'h00);
    send_frame(PACKET_BYTES);
    fill_frame(START_BYTE);
    send_frame(PACKET_BYTES);
    send_byte(STOP_BYTE_A);
    fill_frame(STOP_BYTE_A);
    for (int c = 0; c < CHANNELS; c++)
      put_sample(c, (c % 2 == 0) ? 24'h800000 : 24'h7FFFFF);
    send_frame(PACKET_BYTES);

    // zero scale
    drain();
    apb_access(1'b1, SCALE_ADDR, '0);
    fill_frame(STOP_BYTE_B);
    for (int c = 0; c < CHANNELS; c++)
      put_sample(c, pick_sample());
    send_frame(PACKET_BYTES);

    // ---- random ----
    packet_bytes_sent = 0;
    pkt = 0;
    while (packet_bytes_sent < RANDOM_BYTES) begin
      if (pkt % 4 == 0)
        rescale();
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      // long result-side hold while bytes keep flowing
      if (pkt == 1)
        hold_req = 1'b1;

      // noise while hunting; never a start byte
      repeat ($urandom_range(0, 3)) begin
        nb = BYTE_W'($urandom());
        if (nb == START_BYTE)
          nb = nb ^ 8'h01;
        send_byte(nb);
      end

      if ($urandom_range(0, 9) == 0)
        stop_b = BYTE_W'($urandom());
      else
        stop_b = $urandom_range(0, 1) ? STOP_BYTE_A : STOP_BYTE_B;
      fill_frame(stop_b);
      for (int c = 0; c < CHANNELS; c++)
        put_sample(c, pick_sample());
      if ($urandom_range(0, 3) == 0)
        frame[$urandom_range(1, PACKET_BYTES - 2)] =
          $urandom_range(0, 1) ? START_BYTE : STOP_BYTE_A;

      // occasional cut-off packet; the next bytes continue it
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PACKET_BYTES - 1)
                                           : PACKET_BYTES;
      send_frame(nbytes);
      pkt++;
    end

    // last part without idling
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (3) begin
      fill_frame($urandom_range(0, 1) ? STOP_BYTE_A : STOP_BYTE_B);
      for (int c = 0; c < CHANNELS; c++)
        put_sample(c, pick_sample());
      send_frame(PACKET_BYTES);
    end
    drain();

    if (error_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/spd_pkg.sv
hdl/spd_byte_if.sv
hdl/spd_result_if.sv
hdl/spd_cfg_regs.sv
hdl/spd_deframer.sv
hdl/spd_emitter.sv
hdl/sensor_packet_deframer_24bit_unit.sv
tb/sv/deframer_checker.sv
tb/sv/sensor_packet_deframer_24bit_unit_tb.sv
